FILE: rtl/assert_macros.svh
// Assertion macros for the classifier RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: expression does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/wsoc_pkg.sv
// Package: types, constants and byte classifiers for the word spell-out classifier.
`timescale 1ns / 1ps

package wsoc_pkg;

   localparam int PairTableBytes = 86;
   localparam int Alphabet       = 26;

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_N     = 8'h6e;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_Y     = 8'h79;
   localparam logic [7:0] CHAR_Z     = 8'h7a;

   localparam logic [2:0] POS_MAX     = 3'd7;
   localparam logic [2:0] POS_LATE_S  = 3'd5;
   localparam logic [2:0] POS_LATE    = 3'd4;
   localparam logic [2:0] POS_EARLY   = 3'd3;
   localparam logic [2:0] LEN_PAIR    = 3'd2;

   // Valid initial letter pairs, bit (first*26 + second)
   localparam logic [7:0] PAIR_OK [PairTableBytes] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h22, 8'h08, 8'h00, 8'h88,
      8'h20, 8'h24, 8'h20, 8'h80, 8'h10, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h28, 8'h08, 8'h00, 8'h88, 8'h22, 8'h04, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h88, 8'h22, 8'h04, 8'h00, 8'h02, 8'h00, 8'h00,
      8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h28, 8'h8a, 8'h03, 8'h00, 8'h00, 8'h40, 8'h00,
      8'h02, 8'h00, 8'h41, 8'hca, 8'h9b, 8'h06, 8'h20, 8'h80,
      8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h08, 8'h00,
      8'h08, 8'h20, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h22, 8'h00, 8'h01, 8'h00
   };

   typedef struct packed {
      logic [2:0] letters_seen;
      logic [7:0] lead_letter;
      logic [7:0] second_letter;
      logic [2:0] vowel_position;
      logic       apostrophe_seen;
      logic       scan_aborted;
      logic       pattern_pass;
   } word_state_type;

   localparam word_state_type WORD_CLEAR = '0;

   function automatic logic is_terminator(input logic [7:0] b);
      return (b == CHAR_NUL) || (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic is_vowel(input logic [7:0] b);
      return (b == CHAR_A) || (b == CHAR_E) || (b == CHAR_I) ||
             (b == CHAR_O) || (b == CHAR_U) || (b == CHAR_Y);
   endfunction

   function automatic logic is_lower(input logic [7:0] b);
      return (b >= CHAR_A) && (b <= CHAR_Z);
   endfunction

   function automatic logic is_exception_pair(input logic [7:0] a, input logic [7:0] b);
      return ((a == CHAR_APOS) && (b == CHAR_S)) || ((a == CHAR_S) && (b == CHAR_T)) ||
             ((a == CHAR_N) && (b == CHAR_D)) || ((a == CHAR_R) && (b == CHAR_D)) ||
             ((a == CHAR_T) && (b == CHAR_H));
   endfunction

   // Both letters must already be in a-z
   function automatic logic pair_is_valid(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] ai;
      logic [4:0] bi;
      logic [9:0] idx;
      logic [7:0] row;
      ai  = 5'(a - CHAR_A);
      bi  = 5'(b - CHAR_A);
      idx = 10'(ai * 10'(Alphabet)) + 10'(bi);
      row = PAIR_OK[7'(idx >> 3)];
      return row[idx[2:0]];
   endfunction

endpackage

FILE: rtl/wsoc_decide.sv
// Spell-out decision for a finished word, from the word state and its terminator.
`timescale 1ns / 1ps

module wsoc_decide (
   input  wsoc_pkg::word_state_type word_state,
   input  logic [7:0]               term_byte,
   output logic                     spell_out
);

   logic [2:0] vpos;
   logic       lead_is_s;

   assign vpos      = word_state.vowel_position;
   assign lead_is_s = (word_state.lead_letter == wsoc_pkg::CHAR_S);

   always_comb begin
      if (word_state.letters_seen == '0) begin
         spell_out = !((term_byte == wsoc_pkg::CHAR_NUL) || (term_byte == wsoc_pkg::CHAR_SPACE));
      end else if (word_state.pattern_pass && (word_state.letters_seen == wsoc_pkg::LEN_PAIR)
                   && (term_byte == wsoc_pkg::CHAR_SPACE)) begin
         spell_out = 1'b0;
      end else if (word_state.scan_aborted) begin
         spell_out = 1'b0;
      end else if ((vpos == '0) || (vpos > wsoc_pkg::POS_LATE_S)) begin
         spell_out = 1'b1;
      end else if (!lead_is_s && (vpos > wsoc_pkg::POS_LATE)) begin
         spell_out = 1'b1;
      end else if (vpos < wsoc_pkg::POS_EARLY) begin
         spell_out = 1'b0;
      end else if (word_state.apostrophe_seen) begin
         spell_out = 1'b0;
      end else if (!wsoc_pkg::is_lower(word_state.lead_letter) ||
                   !wsoc_pkg::is_lower(word_state.second_letter)) begin
         spell_out = 1'b1;
      end else begin
         spell_out = !wsoc_pkg::pair_is_valid(word_state.lead_letter, word_state.second_letter);
      end
   end

endmodule

FILE: rtl/word_spell_out_classifier_top.sv
// Top level of the word spell-out classifier: word state, decision and result register.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_text_byte[7:0]
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_spell_out
//
// One byte per cycle while req_stall is low; the result for a terminator appears in the cycle after acceptance.
// Throughput is set by the single result register: a new byte is taken whenever that
// register is empty or its transaction completes in the same cycle.
// Bytes that are not terminators give no transaction on rsp.
// Synchronous reset clears the word state and the result valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module word_spell_out_classifier_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_spell_out
);

   wsoc_pkg::word_state_type state_ff;
   wsoc_pkg::word_state_type state_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_spell_out_ff;
   logic                     rsp_spell_out_in;
   logic                     req_accept;
   logic                     is_term;
   logic                     decision;
   logic [2:0]               pos;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_term    = wsoc_pkg::is_terminator(req_text_byte);
   assign pos        = (state_ff.letters_seen < wsoc_pkg::POS_MAX) ?
                       3'(state_ff.letters_seen + 3'd1) : wsoc_pkg::POS_MAX;

   wsoc_decide u_decide (
      .word_state (state_ff),
      .term_byte  (req_text_byte),
      .spell_out  (decision)
   );

   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         if (is_term) begin
            state_in = wsoc_pkg::WORD_CLEAR;
         end else begin
            if (state_ff.letters_seen == 3'd0) begin
               state_in.lead_letter = req_text_byte;
            end else if (state_ff.letters_seen == 3'd1) begin
               state_in.second_letter = req_text_byte;
               state_in.pattern_pass  =
                  wsoc_pkg::is_exception_pair(state_ff.lead_letter, req_text_byte);
            end
            if ((state_ff.vowel_position == '0) && !state_ff.scan_aborted) begin
               if (wsoc_pkg::is_vowel(req_text_byte)) begin
                  state_in.vowel_position = pos;
               end else if (req_text_byte == wsoc_pkg::CHAR_APOS) begin
                  state_in.apostrophe_seen = 1'b1;
               end else if (!wsoc_pkg::is_lower(req_text_byte)) begin
                  state_in.scan_aborted = 1'b1;
               end
            end
            state_in.letters_seen = pos;
         end
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_spell_out_in = rsp_spell_out_ff;
      if (req_accept && is_term) begin
         rsp_valid_in     = 1'b1;
         rsp_spell_out_in = decision;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsoc_pkg::WORD_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_spell_out_ff <= rsp_spell_out_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_spell_out = rsp_spell_out_ff;

   `ASSERT_ALWAYS(a_vowel_within_word, state_ff.vowel_position <= state_ff.letters_seen)
   `ASSERT_IMPLIES(a_abort_excludes_vowel, state_ff.scan_aborted, state_ff.vowel_position == '0)
   `ASSERT_NEXT(a_term_clears_word, req_accept && is_term, state_ff.letters_seen == '0)
   `ASSERT_NEXT(a_term_gives_result, req_accept && is_term, rsp_valid_ff)
   `ASSERT_NEXT(a_letter_no_result, req_accept && !is_term && !rsp_valid_ff, !rsp_valid_ff)

endmodule

FILE: dv/tb_word_spell_out_classifier_top.sv
// Testbench for the word spell-out classifier: directed and random text against a predictor.
`timescale 1ns / 1ps
module tb_word_spell_out_classifier_top;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ALPHABET     = 26;

   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_VT    = 8'h0b;
   localparam logic [7:0] BYTE_CR    = 8'h0d;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_APOS  = 8'h27;
   localparam logic [7:0] BYTE_HIGH  = 8'hff;
   localparam logic [7:0] LOW_A      = "a";
   localparam logic [7:0] LOW_Z      = "z";

   // valid initial letter pairs, bit (first * 26 + second)
   localparam logic [7:0] ONSET_TABLE [86] = '{
      8'h00, 8'h00, 8'h00, 8'h00, 8'h22, 8'h08, 8'h00, 8'h88,
      8'h20, 8'h24, 8'h20, 8'h80, 8'h10, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h28, 8'h08, 8'h00, 8'h88, 8'h22, 8'h04, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h88, 8'h22, 8'h04, 8'h00, 8'h02, 8'h00, 8'h00,
      8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h28, 8'h8a, 8'h03, 8'h00, 8'h00, 8'h40, 8'h00,
      8'h02, 8'h00, 8'h41, 8'hca, 8'h9b, 8'h06, 8'h20, 8'h80,
      8'h91, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20, 8'h08, 8'h00,
      8'h08, 8'h20, 8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h22, 8'h00, 8'h01, 8'h00
   };

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall     = 1'b0;
   logic       rsp_spell_out;

   // predictor's view of the word in progress
   logic [2:0] word_len  = '0;
   logic [7:0] first_ch  = '0;
   logic [7:0] second_ch = '0;
   logic [2:0] vowel_at  = '0;
   logic       saw_apos  = 1'b0;
   logic       aborted   = 1'b0;
   logic       exc_pair  = 1'b0;

   logic expected_flags [$];

   int errors        = 0;
   int cycles        = 0;
   int bytes_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;

   word_spell_out_classifier_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_spell_out (rsp_spell_out)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   function automatic bit is_gap_byte(input logic [7:0] b);
      return b == BYTE_NUL || b == BYTE_SPACE || (b >= BYTE_TAB && b <= BYTE_CR);
   endfunction

   function automatic bit is_vowel_byte(input logic [7:0] b);
      return b == "a" || b == "e" || b == "i" || b == "o" || b == "u" || b == "y";
   endfunction

   function automatic bit is_small_letter(input logic [7:0] b);
      return b >= LOW_A && b <= LOW_Z;
   endfunction

   // both bytes must be in a-z
   function automatic bit onset_listed(input logic [7:0] a, input logic [7:0] b);
      int idx;
      idx = (int'(a) - int'(LOW_A)) * ALPHABET + (int'(b) - int'(LOW_A));
      return ONSET_TABLE[idx / 8][idx % 8];
   endfunction

   function automatic logic word_flag(input logic [7:0] term);
      if (word_len == 3'd0)
         return !(term == BYTE_NUL || term == BYTE_SPACE);
      if (exc_pair && word_len == 3'd2 && term == BYTE_SPACE)
         return 1'b0;
      if (aborted)
         return 1'b0;
      if (vowel_at == 3'd0 || vowel_at > 3'd5)
         return 1'b1;
      if (first_ch != "s" && vowel_at > 3'd4)
         return 1'b1;
      if (vowel_at < 3'd3)
         return 1'b0;
      if (saw_apos)
         return 1'b0;
      if (!is_small_letter(first_ch) || !is_small_letter(second_ch))
         return 1'b1;
      return !onset_listed(first_ch, second_ch);
   endfunction

   function automatic void track_byte(input logic [7:0] b);
      logic [2:0] pos;
      if (is_gap_byte(b)) begin
         expected_flags.push_back(word_flag(b));
         word_len  = '0;
         first_ch  = '0;
         second_ch = '0;
         vowel_at  = '0;
         saw_apos  = 1'b0;
         aborted   = 1'b0;
         exc_pair  = 1'b0;
         return;
      end
      if (word_len == 3'd0) begin
         first_ch = b;
      end else if (word_len == 3'd1) begin
         second_ch = b;
         exc_pair  = (first_ch == BYTE_APOS && b == "s") || (first_ch == "s" && b == "t") ||
                     (first_ch == "n" && b == "d") || (first_ch == "r" && b == "d") ||
                     (first_ch == "t" && b == "h");
      end
      pos = (word_len < 3'd7) ? word_len + 3'd1 : 3'd7;
      if (vowel_at == 3'd0 && !aborted) begin
         if (is_vowel_byte(b))
            vowel_at = pos;
         else if (b == BYTE_APOS)
            saw_apos = 1'b1;
         else if (!is_small_letter(b))
            aborted = 1'b1;
      end
      if (word_len < 3'd7)
         word_len = word_len + 3'd1;
   endfunction

   // called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_text_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_str(input string s);
      foreach (s[i])
         send_byte(s[i]);
   endtask

   function automatic logic [7:0] word_char();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         c = LOW_A + 8'($urandom_range(0, 25));
      end else if (r < 92) begin
         c = BYTE_APOS;
      end else begin
         do c = 8'($urandom); while (is_gap_byte(c));
      end
      return c;
   endfunction

   function automatic logic [7:0] gap_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return BYTE_SPACE;
      if (r < 75)
         return BYTE_NUL;
      return 8'($urandom_range(int'(BYTE_TAB), int'(BYTE_CR)));
   endfunction

   function automatic logic [7:0] consonant();
      logic [7:0] c;
      do c = LOW_A + 8'($urandom_range(0, 25)); while (is_vowel_byte(c));
      return c;
   endfunction

   task automatic send_random_word();
      int         kind;
      int         tries;
      logic [7:0] a;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // raw noise, terminators included
         repeat ($urandom_range(1, 6))
            send_byte(8'($urandom));
      end else if (kind < 22) begin
         case ($urandom_range(0, 4))
            0: begin a = BYTE_APOS; b = "s"; end
            1: begin a = "s"; b = "t"; end
            2: begin a = "n"; b = "d"; end
            3: begin a = "r"; b = "d"; end
            default: begin a = "t"; b = "h"; end
         endcase
         send_byte(a);
         send_byte(b);
         if ($urandom_range(0, 3) == 0)
            send_byte(word_char());
         send_byte(($urandom_range(0, 9) < 7) ? BYTE_SPACE : gap_char());
      end else if (kind < 50) begin
         // consonant onset, mostly one the table lists
         tries = 0;
         do begin
            a = consonant();
            b = consonant();
            tries++;
         end while (!onset_listed(a, b) && tries < 40 && $urandom_range(0, 9) != 0);
         if ($urandom_range(0, 3) == 0)
            a = "s";
         send_byte(a);
         send_byte(b);
         if ($urandom_range(0, 1) == 0) begin
            send_byte(consonant());
            if ($urandom_range(0, 1) == 0)
               send_byte(consonant());
         end
         if ($urandom_range(0, 9) != 0)
            send_byte(LOW_A + 8'($urandom_range(0, 25)));
         repeat ($urandom_range(0, 3))
            send_byte(word_char());
         send_byte(gap_char());
      end else begin
         repeat ($urandom_range(1, 9))
            send_byte(word_char());
         send_byte(gap_char());
      end
   endtask

   task automatic random_text(input int n_bytes);
      int stop_at;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at)
         send_random_word();
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      send_byte(BYTE_SPACE);   // empty word, space
      send_byte(BYTE_VT);      // empty word, other whitespace
      send_byte(BYTE_NUL);     // empty word, zero
      send_str("'s ");         // exception word
      send_str("th\n");        // exception pair not ended by a space
      send_byte(BYTE_HIGH);    // aborted scan
      send_byte(BYTE_CR);
      send_str("spy ");        // vowel at three, table decides
      send_str("strzy ");      // late vowel after initial s
      send_str("c'ra");        // apostrophe before vowel
      send_byte(BYTE_NUL);
   endtask

   task automatic test_stalled_receiver();
      send_idle_pct = 11;
      stall_pct     = 87;
      random_text(320);
   endtask

   task automatic test_sparse_sender();
      send_idle_pct = 87;
      stall_pct     = 11;
      random_text(320);
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      stall_pct     = 0;
      random_text(300);
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin : check_results
      logic want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_flags.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction: expected none, actual spell_out=%0b",
                     $time, rsp_spell_out);
         end else begin
            want = expected_flags.pop_front();
            if (want !== rsp_spell_out) begin
               errors++;
               $display("%0t: spell_out mismatch: expected %0b, actual %0b",
                        $time, want, rsp_spell_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_stalled_receiver();
      test_sparse_sender();
      test_full_rate();
      req_valid <= 1'b0;
      while (expected_flags.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
